// ----- src/sha256_stream_hasher_core_defines.svh -----
// ----------------------------------------------------------------------------
// SHA-256 stream hasher - assertion macros
// Shared property shorthands for the checker; clocked on clk_i and
// disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SHA256_STREAM_HASHER_CORE_DEFINES_SVH
`define SHA256_STREAM_HASHER_CORE_DEFINES_SVH

// Same-cycle implication.
`define SHA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SHA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/sha256sh_pkg.sv -----
// ----------------------------------------------------------------------------
// SHA-256 stream hasher - package
// Sequencer types, control bundle, round constants and the sigma functions.
// ----------------------------------------------------------------------------
package sha256sh_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    PAD_ONE,
    PAD_ZERO,
    PAD_LEN,
    PAD_DONE
  } pad_e;

  localparam logic [7:0] PadMarker = 8'h80;
  localparam logic [5:0] LenPos    = 6'd56;
  localparam logic [5:0] LastByte  = 6'd63;
  localparam logic [5:0] LastRound = 6'd63;
  localparam logic [2:0] LastWord  = 3'd7;

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Control bundle from the sequencer to the datapath.
  typedef struct packed {
    logic       absorb;
    logic [7:0] msg_byte;
    logic       word_done;
    logic       load_vars;
    logic       round_en;
    logic [5:0] round_idx;
    logic       add_chain;
    logic       init_chain;
    logic       out_load;
    logic [2:0] out_idx;
  } ctrl_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    logic [63:0] dbl;
    dbl = {x, x} >> n;
    return dbl[31:0];
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

// ----- src/sha256sh_sched.sv -----
// ----------------------------------------------------------------------------
// SHA-256 stream hasher - message schedule
// Packs bytes big-endian into words and runs the 16-word schedule window.
// ----------------------------------------------------------------------------
module sha256sh_sched import sha256sh_pkg::*; (
  input  logic        clk_i,
  input  ctrl_t       ctrl_i,
  output logic [31:0] w_o
);

  logic [23:0] stage_q;
  logic [31:0] win_q [16];
  logic [31:0] shift_in;
  logic        shift_en;

  always_comb begin
    shift_en = ctrl_i.word_done | ctrl_i.round_en;
    if (ctrl_i.round_en) begin
      shift_in = small_sigma1(win_q[14]) + win_q[9] + small_sigma0(win_q[1]) + win_q[0];
    end else begin
      shift_in = {stage_q, ctrl_i.msg_byte};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.absorb) begin
      stage_q <= {stage_q[15:0], ctrl_i.msg_byte};
    end
    if (shift_en) begin
      for (int i = 0; i < 15; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[15] <= shift_in;
    end
  end

  assign w_o = win_q[0];

endmodule

// ----- src/sha256sh_round.sv -----
// ----------------------------------------------------------------------------
// SHA-256 stream hasher - round unit
// Working variables, one compression round per cycle, and the chaining value.
// ----------------------------------------------------------------------------
module sha256sh_round import sha256sh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ctrl_t       ctrl_i,
  input  logic [31:0] w_i,
  output logic [31:0] digest_o
);

  logic [31:0] var_q [8];
  logic [31:0] var_d [8];
  logic [31:0] chain_q [8];
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] ch;
  logic [31:0] maj;

  always_comb begin
    ch  = (var_q[4] & var_q[5]) ^ (~var_q[4] & var_q[6]);
    maj = (var_q[0] & var_q[1]) ^ (var_q[0] & var_q[2]) ^ (var_q[1] & var_q[2]);
    t1  = var_q[7] + big_sigma1(var_q[4]) + ch + RoundK[ctrl_i.round_idx] + w_i;
    t2  = big_sigma0(var_q[0]) + maj;
    var_d[0] = t1 + t2;
    var_d[1] = var_q[0];
    var_d[2] = var_q[1];
    var_d[3] = var_q[2];
    var_d[4] = var_q[3] + t1;
    var_d[5] = var_q[4];
    var_d[6] = var_q[5];
    var_d[7] = var_q[6];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_vars) begin
      var_q <= chain_q;
    end else if (ctrl_i.round_en) begin
      var_q <= var_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= InitHash;
    end else if (ctrl_i.init_chain) begin
      chain_q <= InitHash;
    end else if (ctrl_i.add_chain) begin
      for (int i = 0; i < 8; i++) begin
        chain_q[i] <= chain_q[i] + var_q[i];
      end
    end
  end

  assign digest_o = chain_q[ctrl_i.out_idx];

endmodule

// ----- src/sha256sh_ctrl.sv -----
// ----------------------------------------------------------------------------
// SHA-256 stream hasher - sequencer
// Byte intake, padding, round counting and digest readout.
// ----------------------------------------------------------------------------
module sha256sh_ctrl import sha256sh_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_valid_i,
  input  logic [7:0] s_data_i,
  input  logic       s_byte_valid_i,
  input  logic       s_eom_i,
  input  logic       out_free_i,
  output logic       s_ready_o,
  output ctrl_t      ctrl_o
);

  state_e      state_q, state_d;
  pad_e        pad_q, pad_d;
  logic        fin_q, fin_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [63:0] len_q, len_d;
  logic [5:0]  rnd_q, rnd_d;
  logic [2:0]  sub_q, sub_d;

  logic        absorb;
  logic [7:0]  abyte;
  logic [5:0]  cnt_inc;
  logic [63:0] len_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pad_q   <= PAD_ONE;
      fin_q   <= 1'b0;
      cnt_q   <= '0;
      len_q   <= '0;
      rnd_q   <= '0;
      sub_q   <= '0;
    end else begin
      state_q <= state_d;
      pad_q   <= pad_d;
      fin_q   <= fin_d;
      cnt_q   <= cnt_d;
      len_q   <= len_d;
      rnd_q   <= rnd_d;
      sub_q   <= sub_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    pad_d     = pad_q;
    fin_d     = fin_q;
    cnt_d     = cnt_q;
    len_d     = len_q;
    rnd_d     = rnd_q;
    sub_d     = sub_q;
    s_ready_o = 1'b0;
    absorb    = 1'b0;
    abyte     = '0;
    cnt_inc   = cnt_q + 6'd1;
    len_sh    = len_q << {sub_q, 3'b000};
    ctrl_o    = '0;
    ctrl_o.round_idx = rnd_q;
    ctrl_o.out_idx   = sub_q;

    case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          if (s_byte_valid_i) begin
            absorb = 1'b1;
            abyte  = s_data_i;
            len_d  = len_q + 64'd8;
          end
          if (s_eom_i) begin
            fin_d   = 1'b1;
            pad_d   = PAD_ONE;
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        case (pad_q)
          PAD_ONE, PAD_ZERO: begin
            absorb = 1'b1;
            abyte  = (pad_q == PAD_ONE) ? PadMarker : 8'h00;
            if (cnt_inc == LenPos) begin
              pad_d = PAD_LEN;
              sub_d = '0;
            end else begin
              pad_d = PAD_ZERO;
            end
          end
          PAD_LEN: begin
            absorb = 1'b1;
            abyte  = len_sh[63:56];
            sub_d  = sub_q + 3'd1;
            if (sub_q == LastWord) begin
              pad_d = PAD_DONE;
            end
          end
          default: begin
            state_d = ST_OUT;
            sub_d   = '0;
          end
        endcase
      end
      ST_ROUND: begin
        ctrl_o.round_en = 1'b1;
        rnd_d = rnd_q + 6'd1;
        if (rnd_q == LastRound) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        ctrl_o.add_chain = 1'b1;
        if (!fin_q) begin
          state_d = ST_IDLE;
        end else if (pad_q == PAD_DONE) begin
          state_d = ST_OUT;
          sub_d   = '0;
        end else begin
          state_d = ST_PAD;
        end
      end
      ST_OUT: begin
        if (out_free_i) begin
          ctrl_o.out_load = 1'b1;
          sub_d = sub_q + 3'd1;
          if (sub_q == LastWord) begin
            ctrl_o.init_chain = 1'b1;
            len_d   = '0;
            fin_d   = 1'b0;
            pad_d   = PAD_ONE;
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Byte intake: a full block starts the rounds.
    if (absorb) begin
      cnt_d            = cnt_inc;
      ctrl_o.absorb    = 1'b1;
      ctrl_o.msg_byte  = abyte;
      ctrl_o.word_done = (cnt_q[1:0] == 2'b11);
      if (cnt_q == LastByte) begin
        ctrl_o.load_vars = 1'b1;
        rnd_d   = '0;
        state_d = ST_ROUND;
      end
    end
  end

endmodule

// ----- src/sha256_stream_hasher_core.sv -----
// ----------------------------------------------------------------------------
// SHA-256 stream hasher - top level
// Byte-wide SHA-256 engine with a digest word output stream.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side takes one item per transfer: tdata = message byte, tuser =
//   byte-valid flag, tlast = end of message. An item with tuser low carries no
//   byte, so tlast alone closes an empty message.
//   Master side returns the 256-bit digest as eight 32-bit words, H0 first:
//   tdata = digest word, tuser = word index, tlast on the eighth word.
// Timing:
//   A byte that does not complete a block is absorbed while the sequencer stays
//   idle. The 64th byte of a block starts the rounds, then the chain add, on the
//   round unit; no input is taken until they are done. End of message feeds
//   9 to 72 pad bytes through the same intake at one per cycle outside the
//   rounds, runs one or two more compressions, then reads out the eight words.
//   s_axis_tready_o is high only while the sequencer waits for input.
// Reset: chaining value goes to the initial hash, counts and length clear.
// Stalls: a stalled master side holds the word in the output register and
//   the readout waits; the next message may start once word 7 is loaded.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_core import sha256sh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tuser_i,   // [0] byte_valid
  input  logic        s_axis_tlast_i,   // end_of_message
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] digest_word
  output logic [2:0]  m_axis_tuser_o,   // [2:0] word_index
  output logic        m_axis_tlast_o    // last_word
);

  ctrl_t       ctrl;
  logic [31:0] w_t;
  logic [31:0] digest_word;
  logic        out_free;

  logic        out_valid_q;
  logic [31:0] out_word_q;
  logic [2:0]  out_idx_q;
  logic        out_last_q;

  // Output register may be refilled in the cycle its word is taken.
  assign out_free = !out_valid_q || m_axis_tready_i;

  sha256sh_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_valid_i      (s_axis_tvalid_i),
    .s_data_i       (s_axis_tdata_i),
    .s_byte_valid_i (s_axis_tuser_i),
    .s_eom_i        (s_axis_tlast_i),
    .out_free_i     (out_free),
    .s_ready_o      (s_axis_tready_o),
    .ctrl_o         (ctrl)
  );

  sha256sh_sched u_sched (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .w_o    (w_t)
  );

  sha256sh_round u_round (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .w_i      (w_t),
    .digest_o (digest_word)
  );

  // Hold the valid flag; drop it once the word is taken and nothing replaces it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.out_load) begin
      out_word_q <= digest_word;
      out_idx_q  <= ctrl.out_idx;
      out_last_q <= (ctrl.out_idx == LastWord);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_word_q;
  assign m_axis_tuser_o  = out_idx_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

// ----- src/sha256sh_checker.sv -----
// ----------------------------------------------------------------------------
// SHA-256 stream hasher - port checker
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
`include "sha256_stream_hasher_core_defines.svh"

module sha256sh_checker import sha256sh_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        s_axis_tlast_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic [2:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  logic        out_xfer;
  logic        out_stall;
  logic        out_more;
  logic        in_eom_xfer;
  logic        last_ok;
  logic [35:0] out_beat;

  assign out_xfer    = m_axis_tvalid_o && m_axis_tready_i;
  assign out_stall   = m_axis_tvalid_o && !m_axis_tready_i;
  assign out_more    = out_xfer && !m_axis_tlast_o;
  assign in_eom_xfer = s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i;
  assign last_ok     = m_axis_tlast_o == (m_axis_tuser_o == LastWord);
  assign out_beat    = {m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o};

  // Stalled output holds.
  `SHA_ASSERT_NXT(a_out_hold, out_stall, m_axis_tvalid_o && $stable(out_beat), "stalled output moved")

  // Last flag marks word seven only.
  `SHA_ASSERT_IMP(a_last_idx, m_axis_tvalid_o, last_ok, "tlast does not match word index")

  // Digest words follow back to back in index order.
  `SHA_ASSERT_NXT(a_idx_seq, out_more, m_axis_tvalid_o && (m_axis_tuser_o == $past(m_axis_tuser_o) + 3'd1), "index out of order")

  // No intake during readout.
  `SHA_ASSERT_IMP(a_busy_out, m_axis_tvalid_o && !m_axis_tlast_o, !s_axis_tready_o, "input taken in readout")

  // End of message starts finalization.
  `SHA_ASSERT_NXT(a_eom_busy, in_eom_xfer, !s_axis_tready_o, "input ready right after end of message")

endmodule

bind sha256_stream_hasher_core sha256sh_checker u_checker (.*);

// ----- test/sha256_digest_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 stream hasher - digest checker
// Watches both stream channels. Every byte transfer is fed into a local
// SHA-256 predictor; every end-of-message transfer queues eight digest words,
// which are then matched in order against the words leaving the block.
// ----------------------------------------------------------------------------
module sha256_digest_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tuser_i,   // [0] byte_valid
  input  logic        s_axis_tlast_i,   // end_of_message
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [31:0] m_axis_tdata_i,   // [31:0] digest_word
  input  logic [2:0]  m_axis_tuser_i,   // [2:0] word_index
  input  logic        m_axis_tlast_i,   // last_word
  output int          fail_count_o,
  output int          words_due_o
);

  localparam logic [7:0] PAD_MARK      = 8'h80;
  localparam logic [5:0] LEN_FIELD_POS = 6'd56;
  localparam logic [5:0] LAST_SLOT     = 6'd63;
  localparam logic [2:0] FINAL_INDEX   = 3'd7;

  localparam logic [31:0] START_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_beat_t;

  logic [31:0]  chain_q [8];
  logic [31:0]  sched_q [16];
  logic [5:0]   fill_q;
  logic [63:0]  bit_len_q;
  digest_beat_t digest_due_q [$];
  int           fail_total;

  assign fail_count_o = fail_total;

  initial fail_total = 0;

  function automatic logic [31:0] ror(input logic [31:0] v, input int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction

  task automatic restart_hash();
    for (int i = 0; i < 8; i++) chain_q[i] = START_HASH[i];
    for (int i = 0; i < 16; i++) sched_q[i] = '0;
    fill_q    = '0;
    bit_len_q = '0;
  endtask

  // Run the 64 rounds over the held block and fold them into the chain.
  task automatic compress_block();
    logic [31:0] v [8];
    logic [31:0] x, y, t1, t2;
    for (int i = 0; i < 8; i++) v[i] = chain_q[i];
    for (int r = 0; r < 64; r++) begin
      if (r >= 16) begin
        x = sched_q[(r + 1) % 16];
        y = sched_q[(r + 14) % 16];
        sched_q[r % 16] = sched_q[r % 16] + (ror(x, 7) ^ ror(x, 18) ^ (x >> 3))
                        + sched_q[(r + 9) % 16] + (ror(y, 17) ^ ror(y, 19) ^ (y >> 10));
      end
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + sched_q[r % 16];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      for (int i = 7; i > 0; i--) v[i] = v[i - 1];
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_q[i] = chain_q[i] + v[i];
    for (int i = 0; i < 16; i++) sched_q[i] = '0;
    fill_q = '0;
  endtask

  // Pack one byte big-endian into the block; compress once it is full.
  task automatic take_byte(input logic [7:0] b);
    int unsigned shift_amt;
    shift_amt = 24 - 8 * fill_q[1:0];
    sched_q[fill_q[5:2]] = sched_q[fill_q[5:2]] | ({24'd0, b} << shift_amt);
    if (fill_q == LAST_SLOT) compress_block();
    else fill_q = fill_q + 6'd1;
  endtask

  // Pad, append the bit length, queue the digest and start over.
  task automatic close_message();
    logic [63:0]  len;
    digest_beat_t beat;
    len = bit_len_q;
    take_byte(PAD_MARK);
    while (fill_q != LEN_FIELD_POS) take_byte(8'h00);
    for (int i = 0; i < 8; i++) take_byte(len[8 * (7 - i) +: 8]);
    for (int i = 0; i < 8; i++) begin
      beat.word  = chain_q[i];
      beat.index = i[2:0];
      beat.last  = (i[2:0] == FINAL_INDEX);
      digest_due_q.push_back(beat);
    end
    restart_hash();
  endtask

  task automatic check_beat();
    digest_beat_t due;
    if (digest_due_q.size() == 0) begin
      $error("digest word %h arrived with nothing expected", m_axis_tdata_i);
      fail_total++;
    end else begin
      due = digest_due_q.pop_front();
      if (m_axis_tdata_i !== due.word) begin
        $error("digest_word: expected %h, actual %h", due.word, m_axis_tdata_i);
        fail_total++;
      end
      if (m_axis_tuser_i !== due.index) begin
        $error("word_index: expected %0d, actual %0d", due.index, m_axis_tuser_i);
        fail_total++;
      end
      if (m_axis_tlast_i !== due.last) begin
        $error("last_word: expected %b, actual %b", due.last, m_axis_tlast_i);
        fail_total++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_hash();
      digest_due_q.delete();
      words_due_o <= 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) check_beat();
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        if (s_axis_tuser_i) begin
          take_byte(s_axis_tdata_i);
          bit_len_q = bit_len_q + 64'd8;
        end
        if (s_axis_tlast_i) close_message();
      end
      words_due_o <= digest_due_q.size();
    end
  end

endmodule

// ----- test/sha256_stream_hasher_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 stream hasher - testbench top
// Streams messages into the hasher and lets the digest checker compare every
// digest word. A short directed set covers empty messages, idle items, bytes
// that close a message, ends without a byte and the byte extremes; random
// messages follow, weighted toward the padding boundaries, with random gaps
// on the sender, random stalls on the receiver, one long receiver hold-off
// that backs the block up, and pauses until all digests are out.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_core_test;

  localparam int unsigned ITEM_TARGET   = 350;
  localparam int unsigned LONG_HOLD     = 800;
  localparam int unsigned SETTLE_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT   = 2000000;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;  // [7:0] data_byte
  logic        s_axis_tuser  = 1'b0;   // [0] byte_valid
  logic        s_axis_tlast  = 1'b0;   // end_of_message
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;           // [31:0] digest_word
  logic [2:0]  m_axis_tuser;           // [2:0] word_index
  logic        m_axis_tlast;           // last_word

  int          fail_count;
  int          words_due;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;
  bit          long_hold_req = 1'b0;

  sha256_stream_hasher_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser),
    .m_axis_tlast_o  (m_axis_tlast)
  );

  sha256_digest_checker u_digest_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .m_axis_tuser_i  (m_axis_tuser),
    .m_axis_tlast_i  (m_axis_tlast),
    .fail_count_o    (fail_count),
    .words_due_o     (words_due)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Bound the run; a hung handshake ends here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Mostly no gap or a short one, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Favor lengths around the point where padding spills into a second block.
  function automatic int unsigned pick_length();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return $urandom_range(0, 8);
    if (r < 7) begin
      case ($urandom_range(0, 7))
        0:       return 55;
        1:       return 56;
        2:       return 57;
        3:       return 63;
        4:       return 64;
        5:       return 65;
        6:       return 119;
        default: return 128;
      endcase
    end
    return $urandom_range(0, 70);
  endfunction

  // Offer one item and hold it until the transfer; then maybe idle a while.
  // A burst caller passes no_gaps so that valid stays high between items.
  task automatic send_item(input logic [7:0] data, input logic has_byte,
                           input logic ends_msg, input bit no_gaps);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= has_byte;
    s_axis_tlast  <= ends_msg;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (has_byte || ends_msg) items_sent++;
    gap = no_gaps ? 0 : pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'($urandom);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Random bytes with stray idle items; the end rides on the last byte or
  // comes as an item of its own.
  task automatic send_message(input int unsigned nbytes, input bit no_gaps);
    bit end_on_byte;
    end_on_byte = (nbytes != 0) && ($urandom_range(0, 1) == 1);
    for (int unsigned k = 0; k < nbytes; k++) begin
      if ($urandom_range(0, 9) == 0) send_item(8'($urandom), 1'b0, 1'b0, no_gaps);
      send_item(8'($urandom), 1'b1, end_on_byte && (k == nbytes - 1), no_gaps);
    end
    if (!end_on_byte) send_item(8'($urandom), 1'b0, 1'b1, no_gaps);
  endtask

  // Drop valid and hold until every queued digest word has come out.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (words_due != 0);
  endtask

  // Receiver: random stalls and ready stretches, plus one long hold-off
  // when the sender asks for it.
  initial begin
    int unsigned low_len;
    int unsigned high_len;
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        low_len = LONG_HOLD;
      end else begin
        low_len = pick_gap();
      end
      if (low_len != 0) begin
        m_axis_tready <= 1'b0;
        repeat (low_len) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      high_len = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
      repeat (high_len) begin
        @(posedge clk_i);
        if (long_hold_req) break;
      end
    end
  end

  initial begin
    int unsigned msg_idx;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty message, then idle items that must change nothing.
    send_item(8'h00, 1'b0, 1'b1, 1'b1);
    send_item(8'hA5, 1'b0, 1'b0, 1'b0);
    send_item(8'h5A, 1'b0, 1'b0, 1'b1);
    // "abc" with the end riding on the last byte.
    send_item(8'h61, 1'b1, 1'b0, 1'b0);
    send_item(8'h62, 1'b1, 1'b0, 1'b1);
    send_item(8'h63, 1'b1, 1'b1, 1'b0);
    // Single-byte messages at the byte extremes.
    send_item(8'h00, 1'b1, 1'b1, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1, 1'b0);
    // End on an item of its own after two bytes.
    send_item(8'h55, 1'b1, 1'b0, 1'b1);
    send_item(8'hAA, 1'b1, 1'b0, 1'b1);
    send_item(8'h3C, 1'b0, 1'b1, 1'b0);
    // Back-to-back empty messages.
    send_item(8'hFF, 1'b0, 1'b1, 1'b1);
    send_item(8'h00, 1'b0, 1'b1, 1'b1);
    wait_drained();

    msg_idx = 0;
    while (items_sent < ITEM_TARGET) begin
      if (msg_idx == 2) begin
        // Stall the readout while messages keep coming so the intake backs up.
        long_hold_req = 1'b1;
        send_message(3, 1'b1);
        send_message(0, 1'b1);
        send_message(9, 1'b1);
      end else begin
        send_message(pick_length(), $urandom_range(0, 3) == 0);
      end
      if (msg_idx == 4 || $urandom_range(0, 5) == 0) wait_drained();
      msg_idx++;
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
